// File: hdl/ccm_pkg.sv
// Package for the consensus cluster mean unit.
// Holds the field widths, register indexes, reset values and request types.
// No dependencies.
package ccm_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int MAX_SAMPLES = 32;
    localparam int CNT_W       = 6;
    localparam int ADDR_W      = 5;
    localparam int WIN_W       = 31;
    localparam int MINC_W      = 6;
    localparam int SUM_W       = 38;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT   = 2'd1;

    localparam logic [WIN_W-1:0]  WINDOW_RESET    = 31'd655360;
    localparam logic [MINC_W-1:0] MIN_COUNT_RESET = 6'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       is_last;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic                       valid_res;
        logic [CNT_W-1:0]           cluster_size;
        logic                       all_agree;
        logic                       overflowed;
    } out_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       store;
        logic                       last;
        logic                       dropped;
    } cmd_t;

endpackage

// File: hdl/ccm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ccm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/ccm_front.sv
// Front end: accepts samples, decides whether each is stored or dropped.
// Depends on ccm_pkg.
module ccm_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ccm_pkg::in_item_t s_data,
    input  logic             q_full,
    output logic             push,
    output ccm_pkg::cmd_t    push_data
);
    import ccm_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             drop_reg, drop_next;
    logic             room;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;
    assign room    = count_reg < CNT_W'(MAX_SAMPLES);

    always_comb begin
        push_data.sample  = s_data.sample;
        push_data.store   = room;
        push_data.last    = s_data.is_last;
        push_data.dropped = drop_reg || !room;
        count_next = count_reg;
        drop_next  = drop_reg;
        if (push) begin
            if (s_data.is_last) begin
                count_next = '0;
                drop_next  = 1'b0;
            end else begin
                if (room) begin
                    count_next = count_reg + 1'b1;
                end else begin
                    drop_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end
endmodule

// File: hdl/ccm_queue.sv
// Short request queue between the front and back ends.
// Depends on ccm_pkg.
module ccm_queue #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ccm_pkg::cmd_t push_data,
    output logic          full,
    output logic          not_empty,
    input  logic          pop,
    output ccm_pkg::cmd_t pop_data
);
    import ccm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = level_reg == LVL_W'(DEPTH);
    assign not_empty = level_reg != '0;
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end
endmodule

// File: hdl/ccm_back.sv
// Back end: keeps the set sorted by insertion, scans for the best cluster,
// sums it and divides bit-serially. Depends on ccm_pkg and ccm_ram.
module ccm_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_not_empty,
    input  ccm_pkg::cmd_t               q_data,
    output logic                        q_pop,
    input  logic [ccm_pkg::WIN_W-1:0]   window_half,
    input  logic [ccm_pkg::MINC_W-1:0]  min_count,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ccm_pkg::out_item_t          m_data
);
    import ccm_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_INS_RD  = 4'd1;
    localparam logic [3:0] ST_INS_CMP = 4'd2;
    localparam logic [3:0] ST_SC_INIT = 4'd3;
    localparam logic [3:0] ST_SC_RDI  = 4'd4;
    localparam logic [3:0] ST_SC_GETI = 4'd5;
    localparam logic [3:0] ST_SC_RDJ  = 4'd6;
    localparam logic [3:0] ST_SC_CMPJ = 4'd7;
    localparam logic [3:0] ST_SUM_RD  = 4'd8;
    localparam logic [3:0] ST_SUM_ACC = 4'd9;
    localparam logic [3:0] ST_DIV_INI = 4'd10;
    localparam logic [3:0] ST_DIV     = 4'd11;
    localparam logic [3:0] ST_OUT     = 4'd12;

    logic [3:0]                 state_reg;
    logic signed [SAMPLE_W-1:0] key_reg, si_reg;
    logic [CNT_W-1:0]           pos_reg, n_reg, j_reg, cr_reg, k_reg, bit_reg;
    logic [ADDR_W-1:0]          i_reg, left_reg;
    logic                       last_reg, drop_reg, neg_reg, valid_reg;
    logic signed [SUM_W-1:0]    acc_reg;
    logic [SUM_W-1:0]           quo_reg;
    logic [CNT_W-1:0]           rem_reg;
    logic                       m_valid_reg;
    out_item_t                  m_data_reg;

    logic                  we;
    logic [ADDR_W-1:0]     waddr, raddr;
    logic [SAMPLE_W-1:0]   wdata, rdata;
    logic signed [SAMPLE_W-1:0] rd_s;
    logic [SAMPLE_W:0]     diff, span;
    logic                  scan_end;
    logic [CNT_W-1:0]      run_len;
    logic [CNT_W:0]        trial;
    logic                  ge;
    logic [SAMPLE_W-1:0]   quo_lo;

    ccm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_store (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign rd_s    = signed'(rdata);
    assign diff    = {rdata[SAMPLE_W-1], rdata} - {si_reg[SAMPLE_W-1], si_reg};
    assign span    = {1'b0, window_half, 1'b0};
    assign run_len = j_reg - CNT_W'(i_reg);
    assign trial   = {rem_reg, quo_reg[SUM_W-1]};
    assign ge      = trial >= {1'b0, cr_reg};
    assign quo_lo  = quo_reg[SAMPLE_W-1:0];
    assign q_pop   = (state_reg == ST_IDLE) && q_not_empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        we       = 1'b0;
        waddr    = pos_reg[ADDR_W-1:0];
        wdata    = key_reg;
        raddr    = '0;
        scan_end = 1'b0;
        unique case (state_reg)
            ST_INS_RD: begin
                if (pos_reg == '0) begin
                    we = 1'b1;
                end else begin
                    raddr = ADDR_W'(pos_reg - 1'b1);
                end
            end
            ST_INS_CMP: begin
                we = 1'b1;
                if (rd_s > key_reg) begin
                    wdata = rdata;
                end
            end
            ST_SC_RDI: raddr = i_reg;
            ST_SC_RDJ: begin
                if (j_reg < n_reg) begin
                    raddr = j_reg[ADDR_W-1:0];
                end else begin
                    scan_end = 1'b1;
                end
            end
            ST_SC_CMPJ: scan_end = diff > span;
            ST_SUM_RD: raddr = ADDR_W'(CNT_W'(left_reg) + k_reg);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_not_empty) begin
                        key_reg  <= q_data.sample;
                        last_reg <= q_data.last;
                        drop_reg <= q_data.dropped;
                        pos_reg  <= n_reg;
                        if (q_data.store) begin
                            state_reg <= ST_INS_RD;
                        end else if (q_data.last) begin
                            state_reg <= ST_SC_INIT;
                        end
                    end
                end
                ST_INS_RD: begin
                    if (pos_reg == '0) begin
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= last_reg ? ST_SC_INIT : ST_IDLE;
                    end else begin
                        state_reg <= ST_INS_CMP;
                    end
                end
                ST_INS_CMP: begin
                    if (rd_s > key_reg) begin
                        pos_reg   <= pos_reg - 1'b1;
                        state_reg <= ST_INS_RD;
                    end else begin
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= last_reg ? ST_SC_INIT : ST_IDLE;
                    end
                end
                ST_SC_INIT: begin
                    i_reg     <= ADDR_W'(n_reg >> 1);
                    left_reg  <= ADDR_W'(n_reg >> 1);
                    cr_reg    <= CNT_W'(1);
                    state_reg <= ST_SC_RDI;
                end
                ST_SC_RDI: state_reg <= ST_SC_GETI;
                ST_SC_GETI: begin
                    si_reg    <= rd_s;
                    j_reg     <= CNT_W'(i_reg) + 1'b1;
                    state_reg <= ST_SC_RDJ;
                end
                ST_SC_RDJ, ST_SC_CMPJ: begin
                    if (scan_end) begin
                        if (run_len > cr_reg) begin
                            cr_reg   <= run_len;
                            left_reg <= i_reg;
                        end
                        if (i_reg == '0) begin
                            k_reg     <= '0;
                            acc_reg   <= '0;
                            state_reg <= ST_SUM_RD;
                        end else begin
                            i_reg     <= i_reg - 1'b1;
                            state_reg <= ST_SC_RDI;
                        end
                    end else if (state_reg == ST_SC_RDJ) begin
                        state_reg <= ST_SC_CMPJ;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_SC_RDJ;
                    end
                end
                ST_SUM_RD: state_reg <= (k_reg < cr_reg) ? ST_SUM_ACC : ST_DIV_INI;
                ST_SUM_ACC: begin
                    acc_reg   <= acc_reg + SUM_W'(rd_s);
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= ST_SUM_RD;
                end
                ST_DIV_INI: begin
                    valid_reg <= {1'b0, cr_reg} >= {1'b0, min_count};
                    neg_reg   <= acc_reg < 0;
                    quo_reg   <= (acc_reg < 0) ? SUM_W'(-acc_reg) : acc_reg;
                    rem_reg   <= '0;
                    bit_reg   <= CNT_W'(SUM_W);
                    state_reg <= ({1'b0, cr_reg} >= {1'b0, min_count}) ? ST_DIV : ST_OUT;
                end
                ST_DIV: begin
                    rem_reg <= ge ? CNT_W'(trial - {1'b0, cr_reg}) : trial[CNT_W-1:0];
                    quo_reg <= {quo_reg[SUM_W-2:0], ge};
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == CNT_W'(1)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.mean         <= !valid_reg ? '0 :
                                                   (neg_reg ? -quo_lo : quo_lo);
                        m_data_reg.valid_res    <= valid_reg;
                        m_data_reg.cluster_size <= cr_reg;
                        m_data_reg.all_agree    <= cr_reg == n_reg;
                        m_data_reg.overflowed   <= drop_reg;
                        n_reg                   <= '0;
                        state_reg               <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// File: hdl/consensus_cluster_mean_unit.sv
// After the last sample of a set, the back end runs the sorted insertion, the cluster scan,
// the summing and the bit-serial divider in turn; the finished result then waits while the
// result register still holds a result that m_ready has not taken.
// Each stored sample is inserted in sorted order before the back end pops the next request.
// Reset: synchronous, active low; clears counts, queue and result valid, and
// restores the register defaults. The sample store is not cleared.
module consensus_cluster_mean_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ccm_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ccm_pkg::out_item_t             m_data,
    input  logic                           cfg_wr_en,
    input  logic [ccm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ccm_pkg::WIN_W-1:0]      cfg_data
);
    import ccm_pkg::*;

    logic              q_full, q_not_empty, push, pop;
    cmd_t              push_data, pop_data;
    logic [WIN_W-1:0]  window_reg;
    logic [MINC_W-1:0] min_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= WINDOW_RESET;
            min_count_reg <= MIN_COUNT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_WINDOW_HALF) begin
                window_reg <= cfg_data;
            end else if (cfg_index == REG_MIN_COUNT) begin
                min_count_reg <= cfg_data[MINC_W-1:0];
            end
        end
    end

    ccm_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .q_full(q_full), .push(push), .push_data(push_data)
    );

    ccm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_data(push_data),
        .full(q_full), .not_empty(q_not_empty), .pop(pop), .pop_data(pop_data)
    );

    ccm_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_not_empty(q_not_empty), .q_data(pop_data),
        .q_pop(pop), .window_half(window_reg), .min_count(min_count_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    a_invalid_mean_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.valid_res |-> m_data.mean == '0)
        else $error("invalid result carries a non-zero mean");

    a_cluster_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.cluster_size != '0 && m_data.cluster_size <= CNT_W'(MAX_SAMPLES))
        else $error("cluster size out of range");

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

// File: verif/tb_consensus_cluster_mean_unit.sv
// Self-checking testbench for the consensus cluster mean unit.
// Depends on ccm_pkg and consensus_cluster_mean_unit; drives sample sets with random idling
// and compares every cluster result against an in-bench model.
module tb_consensus_cluster_mean_unit;
    import ccm_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WIN_W-1:0] cfg_data = '0;

    consensus_cluster_mean_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    in_item_t  pending_samples[$];
    out_item_t expected_means[$];
    logic signed [SAMPLE_W-1:0] set_samples[$];
    logic [WIN_W-1:0]  mdl_window = WINDOW_RESET;
    logic [MINC_W-1:0] mdl_min = MIN_COUNT_RESET;
    logic mdl_drop = 1'b0;
    int errors = 0;
    bit quiet = 0;
    bit hold_send = 0;
    int send_gap = 0;
    int recv_gap = 0;

    function automatic out_item_t cluster_result();
        logic signed [SAMPLE_W-1:0] s[$];
        logic signed [SAMPLE_W-1:0] key;
        out_item_t r;
        int n, i, j, k, cr, left, last_idx;
        logic [33:0] span;
        logic signed [SUM_W+1:0] sum;
        s = set_samples;
        n = s.size();
        for (i = 1; i < n; i++) begin
            key = s[i];
            k = i;
            while (k > 0 && s[k-1] > key) begin
                s[k] = s[k-1];
                k--;
            end
            s[k] = key;
        end
        span = {3'b0, mdl_window} << 1;
        left = n / 2;
        last_idx = n / 2;
        cr = 1;
        for (i = n / 2; i >= 0; i--) begin
            j = i + 1;
            while (j < n && ($signed({2'b0, 32'(0)}) + 34'(signed'(s[j]))
                   - 34'(signed'(s[i]))) <= $signed({1'b0, span})) j++;
            if (j - i > cr) begin
                cr = j - i;
                left = i;
                last_idx = j - 1;
            end
        end
        r = '0;
        r.valid_res = (cr >= mdl_min);
        if (r.valid_res) begin
            sum = 0;
            for (i = left; i <= last_idx; i++) sum += s[i];
            r.mean = SAMPLE_W'(sum / cr);
        end
        r.cluster_size = CNT_W'(cr);
        r.all_agree = (cr == n);
        r.overflowed = mdl_drop;
        return r;
    endfunction

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] v, input logic last);
        in_item_t it;
        it.sample = v;
        it.is_last = last;
        pending_samples.push_back(it);
    endtask

    task automatic push_set(input int n, input int mode);
        int base;
        base = $urandom;
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: push_sample($urandom, i == n - 1);
                1: push_sample(base + $urandom_range(0, 1 << 21), i == n - 1);
                default: push_sample(($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000)
                                     ^ $urandom_range(0, 3), i == n - 1);
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_valid || expected_means.size() != 0)
            @(posedge aclk);
        repeat (19 * MAX_SAMPLES + 60) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_WINDOW_HALF) mdl_window = val;
        else if (idx == REG_MIN_COUNT) mdl_min = val[MINC_W-1:0];
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (set_samples.size() < MAX_SAMPLES) set_samples.push_back(s_data.sample);
                else mdl_drop = 1'b1;
                if (s_data.is_last) begin
                    expected_means.push_back(cluster_result());
                    set_samples.delete();
                    mdl_drop = 1'b0;
                end
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_samples.size() != 0 && !hold_send) begin
                    s_data <= pending_samples.pop_front();
                    s_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 4);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t exp_r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_means.size() == 0) begin
                    $error("result with no set pending");
                    errors++;
                end else begin
                    exp_r = expected_means.pop_front();
                    if (m_data.mean !== exp_r.mean) begin
                        $error("mean exp %0d got %0d", exp_r.mean, m_data.mean); errors++; end
                    if (m_data.valid_res !== exp_r.valid_res) begin
                        $error("valid_res exp %0d got %0d", exp_r.valid_res, m_data.valid_res);
                        errors++; end
                    if (m_data.cluster_size !== exp_r.cluster_size) begin
                        $error("cluster_size exp %0d got %0d", exp_r.cluster_size,
                               m_data.cluster_size); errors++; end
                    if (m_data.all_agree !== exp_r.all_agree) begin
                        $error("all_agree exp %0d got %0d", exp_r.all_agree, m_data.all_agree);
                        errors++; end
                    if (m_data.overflowed !== exp_r.overflowed) begin
                        $error("overflowed exp %0d got %0d", exp_r.overflowed,
                               m_data.overflowed); errors++; end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0) recv_gap <= $urandom_range(1, 4);
            end
        end
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int total, n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests: extremes, a single sample, ties, and a full store with drops.
        push_sample(32'sh7fffffff, 1'b1);
        push_sample(32'sh80000000, 1'b0);
        push_sample(32'sh7fffffff, 1'b0);
        push_sample(32'sh00000000, 1'b1);
        push_sample(32'sh00010000, 1'b0);
        push_sample(32'sh00020000, 1'b0);
        push_sample(32'sh00300000, 1'b0);
        push_sample(32'sh00310000, 1'b1);
        push_sample(-32'sh00050000, 1'b0);
        push_sample(-32'sh00040000, 1'b1);
        wait_drained();
        for (int i = 0; i < 34; i++) push_sample(i << 16, i == 33);
        wait_drained();

        hold_send = 1;
        for (int i = 0; i < 32; i++) push_sample(-i, i == 31);
        hold_send = 0;
        wait_drained();

        total = 0;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(REG_WINDOW_HALF, '0); write_reg(REG_MIN_COUNT, 0); end
                1: begin write_reg(REG_WINDOW_HALF, '1); write_reg(REG_MIN_COUNT, 32); end
                2: begin write_reg(REG_WINDOW_HALF, 31'h00080000); write_reg(REG_MIN_COUNT, 3); end
                3: begin
                    write_reg(REG_WINDOW_HALF, 31'($urandom));
                    write_reg(REG_MIN_COUNT, 63);
                end
                4: begin write_reg(REG_WINDOW_HALF, 31'h00100000); write_reg(REG_MIN_COUNT, 2); end
                default: begin
                    write_reg(REG_WINDOW_HALF, 31'($urandom_range(0, 31'h00400000)));
                    write_reg(REG_MIN_COUNT, 31'($urandom_range(0, 8)));
                    quiet = 1;
                end
            endcase
            while (total < 225 * (phase + 1)) begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
                push_set(n, $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 9) == 0 ? 2 : 1));
                total += n;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: files.f
hdl/ccm_pkg.sv
hdl/ccm_ram.sv
hdl/ccm_front.sv
hdl/ccm_queue.sv
hdl/ccm_back.sv
hdl/consensus_cluster_mean_unit.sv
verif/tb_consensus_cluster_mean_unit.sv
